/* sv/madl_pkg.sv */
`timescale 1ns / 1ps
package madl_pkg;

   localparam int PIX_W     = 32;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 1;
   localparam int POS_W     = 11;
   localparam int GREEN_W   = 8;
   localparam int Q_DEPTH   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [CSR_W-1:0] LINE_WIDTH_RESET   = 12'd640;
   localparam logic [CSR_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   // column position inside a triple
   typedef enum logic [2:0] {
      PH0 = 3'b001,
      PH1 = 3'b010,
      PH2 = 3'b100
   } phase_type;

   // line store bank that the current row writes
   typedef enum logic [2:0] {
      SLOT0 = 3'b001,
      SLOT1 = 3'b010,
      SLOT2 = 3'b100
   } slot_type;

   typedef struct packed {
      logic [POS_W-1:0]           out_row;
      logic [POS_W-1:0]           x;
      logic                       interp;
      logic [2:0][PIX_W-1:0]      upper;
      logic [2:0][PIX_W-1:0]      lower;
   } triple_type;

   typedef struct packed {
      logic full;
      logic almost_full;
      logic empty;
   } q_status_type;

   function automatic logic [GREEN_W-1:0] avg8(input logic [GREEN_W-1:0] a,
                                               input logic [GREEN_W-1:0] b);
      logic [GREEN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[GREEN_W:1];
   endfunction

   function automatic logic [GREEN_W-1:0] green_of(input logic [PIX_W-1:0] p);
      return p[15:8];
   endfunction

   function automatic logic [GREEN_W-1:0] absdiff8(input logic [GREEN_W-1:0] a,
                                                   input logic [GREEN_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // channel-wise floor average, alpha byte cleared
   function automatic logic [PIX_W-1:0] avg_pixel(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
      return {8'h00, avg8(a[23:16], b[23:16]), avg8(a[15:8], b[15:8]),
              avg8(a[7:0], b[7:0])};
   endfunction

endpackage

/* sv/madl_req_if.sv */
`timescale 1ns / 1ps
interface madl_req_if;
   import madl_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

/* sv/madl_rsp_if.sv */
`timescale 1ns / 1ps
interface madl_rsp_if;
   import madl_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] out_row;
   logic [POS_W-1:0] out_col;
   logic [PIX_W-1:0] upper_pixel;
   logic [PIX_W-1:0] lower_pixel;
   logic             interpolated;
   logic             last_of_run;
   modport source (output valid, output out_row, output out_col, output upper_pixel,
                   output lower_pixel, output interpolated, output last_of_run,
                   input ready);
   modport sink (input valid, input out_row, input out_col, input upper_pixel,
                 input lower_pixel, input interpolated, input last_of_run,
                 output ready);
endinterface

/* sv/motion_adaptive_line_deinterlacer_core.sv */
`timescale 1ns / 1ps
// channel   dir  handshake            payload
// req_bus   in   valid/ready          pixel[31:0]
// rsp_bus   out  valid/ready          out_row, out_col, upper_pixel, lower_pixel,
//                                     interpolated, last_of_run
// csr_*     in   csr_we, no wait      csr_index[0], csr_wdata[11:0]
//
// one pixel accepted per clock while the queue has room; a triple is registered,
// queued, then sent by the back end as three words, one per unstalled clock.
// the line store is three single-port banks, read-first at the pixel's column.
// synchronous reset clears counters and queue; the line store is not cleared.
// a stalled rsp_bus holds the back end; pixels keep flowing until the
// two-entry triple queue and the triple in flight fill it.
module motion_adaptive_line_deinterlacer_core #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   madl_req_if.sink                       req_bus,
   madl_rsp_if.source                     rsp_bus,
   input  logic                           csr_we,
   input  logic [madl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [madl_pkg::CSR_W-1:0]     csr_wdata
);
   import madl_pkg::*;

   logic [CSR_W-1:0] line_width_ff, frame_height_ff;
   logic             push, pop;
   triple_type       push_data, pop_data;
   q_status_type     q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:   line_width_ff   <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   madl_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .line_width   (line_width_ff),
      .frame_height (frame_height_ff),
      .q_status     (q_status),
      .push         (push),
      .push_data    (push_data)
   );

   madl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   madl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

/* sv/madl_front.sv */
`timescale 1ns / 1ps
module madl_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   madl_req_if.sink                    req_bus,
   input  logic [madl_pkg::CSR_W-1:0]  line_width,
   input  logic [madl_pkg::CSR_W-1:0]  frame_height,
   input  madl_pkg::q_status_type      q_status,
   output logic                        push,
   output madl_pkg::triple_type        push_data
);
   import madl_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WL = (CSR_W > $clog2(MAX_WIDTH + 1)) ? CSR_W : $clog2(MAX_WIDTH + 1);
   localparam int HL = (CSR_W > $clog2(MAX_HEIGHT + 1)) ? CSR_W : $clog2(MAX_HEIGHT + 1);

   typedef struct packed {
      logic             emit;
      phase_type        phase;
      slot_type         slot;
      logic [PIX_W-1:0] pix;
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] x;
   } pipe_type;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   phase_type     phase_ff, phase_in;
   slot_type      slot_ff, slot_in;
   logic          acc;

   logic [WL-1:0] w_raw, w_eff, col_x;
   logic [HL-1:0] h_raw, h_eff, row_x;
   logic          wrap_col, wrap_row, emit;

   logic          pipe_valid_ff;
   pipe_type      pipe_ff, pipe_in;
   logic [PIX_W-1:0] bank_rd_ff [3];

   logic [PIX_W-1:0]   rm1_pix, y_pix, y1_pix;
   logic [GREEN_W-1:0] hold_m1g_ff;
   logic [1:0][PIX_W-1:0] hold_y_ff, hold_y1_ff, hold_r2_ff;
   logic [GREEN_W-1:0] m1, m2, m3, m4;
   logic [GREEN_W:0]   d1, d2;
   logic               interp;
   logic [2:0][PIX_W-1:0] y_row, y1_row, r2_row;

   // effective frame size, clamped to 1..max
   always_comb begin
      w_raw = WL'(line_width);
      h_raw = HL'(frame_height);
      if (w_raw == '0) w_eff = WL'(1);
      else if (w_raw > WL'(MAX_WIDTH)) w_eff = WL'(MAX_WIDTH);
      else w_eff = w_raw;
      if (h_raw == '0) h_eff = HL'(1);
      else if (h_raw > HL'(MAX_HEIGHT)) h_eff = HL'(MAX_HEIGHT);
      else h_eff = h_raw;
   end

   // one in-flight triple may still land in the queue
   assign req_bus.ready = !q_status.full &&
                          !(q_status.almost_full && pipe_valid_ff && pipe_ff.emit);
   assign acc = req_bus.valid && req_bus.ready;

   always_comb begin
      col_x    = WL'(col_ff);
      row_x    = HL'(row_ff);
      wrap_col = (col_x + WL'(1)) >= w_eff;
      wrap_row = (row_x + HL'(1)) >= h_eff;
      emit     = (phase_ff == PH2) && (col_x < w_eff) && row_ff[0] &&
                 (row_x >= HL'(3)) && (row_x < h_eff);
      col_in   = col_ff;
      row_in   = row_ff;
      phase_in = phase_ff;
      slot_in  = slot_ff;
      if (wrap_col) begin
         col_in   = '0;
         phase_in = PH0;
         if (wrap_row) begin
            row_in  = '0;
            slot_in = SLOT0;
         end else begin
            row_in = RW'(row_x + HL'(1));
            unique case (slot_ff)
               SLOT0:   slot_in = SLOT1;
               SLOT1:   slot_in = SLOT2;
               SLOT2:   slot_in = SLOT0;
               default: slot_in = SLOT0;
            endcase
         end
      end else begin
         col_in = col_ff + CW'(1);
         unique case (phase_ff)
            PH0:     phase_in = PH1;
            PH1:     phase_in = PH2;
            PH2:     phase_in = PH0;
            default: phase_in = PH0;
         endcase
      end
      pipe_in.emit    = emit;
      pipe_in.phase   = phase_ff;
      pipe_in.slot    = slot_ff;
      pipe_in.pix     = req_bus.pixel;
      pipe_in.out_row = POS_W'(row_ff) - POS_W'(3);
      pipe_in.x       = POS_W'(col_ff) - POS_W'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         phase_ff      <= PH0;
         slot_ff       <= SLOT0;
         pipe_valid_ff <= 1'b0;
      end else begin
         pipe_valid_ff <= acc;
         if (acc) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            phase_ff <= phase_in;
            slot_ff  <= slot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) pipe_ff <= pipe_in;
   end

   // three line banks, read-first at the current column
   for (genvar g = 0; g < 3; g++) begin : g_bank
      logic [PIX_W-1:0] bank_mem [MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (acc) begin
            if (slot_ff[g]) bank_mem[col_ff] <= req_bus.pixel;
            bank_rd_ff[g] <= bank_mem[col_ff];
         end
      end
   end

   // rows r-3, r-2 and r-1 at this column
   always_comb begin
      unique case (pipe_ff.slot)
         SLOT0: begin
            rm1_pix = bank_rd_ff[0]; y_pix = bank_rd_ff[1]; y1_pix = bank_rd_ff[2];
         end
         SLOT1: begin
            rm1_pix = bank_rd_ff[1]; y_pix = bank_rd_ff[2]; y1_pix = bank_rd_ff[0];
         end
         SLOT2: begin
            rm1_pix = bank_rd_ff[2]; y_pix = bank_rd_ff[0]; y1_pix = bank_rd_ff[1];
         end
         default: begin
            rm1_pix = bank_rd_ff[0]; y_pix = bank_rd_ff[1]; y1_pix = bank_rd_ff[2];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pipe_valid_ff) begin
         unique case (pipe_ff.phase)
            PH0: begin
               hold_m1g_ff   <= green_of(rm1_pix);
               hold_y_ff[0]  <= y_pix;
               hold_y1_ff[0] <= y1_pix;
               hold_r2_ff[0] <= pipe_ff.pix;
            end
            PH1: begin
               hold_y_ff[1]  <= y_pix;
               hold_y1_ff[1] <= y1_pix;
               hold_r2_ff[1] <= pipe_ff.pix;
            end
            PH2: begin
            end
            default: begin
            end
         endcase
      end
   end

   // motion test on green averages of the outer columns
   always_comb begin
      y_row  = {y_pix, hold_y_ff[1], hold_y_ff[0]};
      y1_row = {y1_pix, hold_y1_ff[1], hold_y1_ff[0]};
      r2_row = {pipe_ff.pix, hold_r2_ff[1], hold_r2_ff[0]};
      m1 = avg8(hold_m1g_ff, green_of(rm1_pix));
      m2 = avg8(green_of(y_row[0]), green_of(y_row[2]));
      m3 = avg8(green_of(y1_row[0]), green_of(y1_row[2]));
      m4 = avg8(green_of(r2_row[0]), green_of(r2_row[2]));
      d1 = {1'b0, absdiff8(m1, m3)} + {1'b0, absdiff8(m2, m4)};
      d2 = {1'b0, absdiff8(m1, m4)} + {1'b0, absdiff8(m2, m3)};
      interp = d1 < d2;
      push_data.out_row = pipe_ff.out_row;
      push_data.x       = pipe_ff.x;
      push_data.interp  = interp;
      push_data.upper   = y_row;
      for (int k = 0; k < 3; k++) begin
         push_data.lower[k] = interp ? avg_pixel(y_row[k], r2_row[k]) : y1_row[k];
      end
   end

   assign push = pipe_valid_ff && pipe_ff.emit;

   a_col_phase: assert property (@(posedge clock) disable iff (reset)
      (col_ff == '0) |-> (phase_ff == PH0))
      else $error("column counter and triple phase out of step");

   a_credit: assert property (@(posedge clock) disable iff (reset)
      (pipe_valid_ff && pipe_ff.emit) |-> !q_status.full)
      else $error("triple reached a full queue");

endmodule

/* sv/madl_queue.sv */
`timescale 1ns / 1ps
module madl_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  madl_pkg::triple_type    push_data,
   input  logic                    pop,
   output madl_pkg::triple_type    pop_data,
   output madl_pkg::q_status_type  status
);
   import madl_pkg::*;

   localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int NW = $clog2(Q_DEPTH + 1);

   triple_type     entry_ff [Q_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]  count_ff;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(Q_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign pop_data           = entry_ff[rd_ptr_ff];
   assign status.full        = count_ff == NW'(Q_DEPTH);
   assign status.almost_full = count_ff >= NW'(Q_DEPTH - 1);
   assign status.empty       = count_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (pop) rd_ptr_ff <= bump(rd_ptr_ff);
         if (push && !pop) count_ff <= count_ff + NW'(1);
         else if (pop && !push) count_ff <= count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue underflow");

endmodule

/* sv/madl_back.sv */
`timescale 1ns / 1ps
module madl_back (
   input  logic                    clock,
   input  logic                    reset,
   input  madl_pkg::q_status_type  q_status,
   input  madl_pkg::triple_type    pop_data,
   output logic                    pop,
   madl_rsp_if.source              rsp_bus
);
   import madl_pkg::*;

   triple_type cur_ff;
   logic       valid_ff;
   logic [1:0] k_ff;
   logic       acc, done;

   assign acc  = rsp_bus.valid && rsp_bus.ready;
   assign done = acc && (k_ff == 2'd2);
   assign pop  = !q_status.empty && (!valid_ff || done);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         k_ff     <= 2'd0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            k_ff     <= 2'd0;
         end else if (done) begin
            valid_ff <= 1'b0;
         end else if (acc) begin
            k_ff <= k_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= pop_data;
   end

   // one word per column of the held triple
   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.out_row      = cur_ff.out_row;
   assign rsp_bus.out_col      = cur_ff.x + POS_W'(k_ff);
   assign rsp_bus.upper_pixel  = cur_ff.upper[k_ff];
   assign rsp_bus.lower_pixel  = cur_ff.lower[k_ff];
   assign rsp_bus.interpolated = cur_ff.interp;
   assign rsp_bus.last_of_run  = k_ff == 2'd2;

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (k_ff != 2'd3))
      else $error("result index past third word");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
   import madl_pkg::*;

   localparam int MAX_W       = 2048;
   localparam int MAX_H       = 2048;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 8;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic [PIX_W-1:0] upper;
      logic [PIX_W-1:0] lower;
      logic             interp;
      logic             last;
   } out_word_type;

   typedef enum int {
      PIX_NOISE,
      PIX_PALETTE,
      PIX_FLAT_GREEN
   } pixel_mode_type;

   // 3 wide, 8 high: rows 0..3 interpolate, rows 2..5 pass through,
   // rows 4..7 tie on the motion test
   localparam logic [PIX_W-1:0] PROBE_FRAME [24] = '{
      32'h00000000, 32'hFFFF00FF, 32'h12340056,
      32'hFFFFFFFF, 32'hA5C3FF5A, 32'h00FFFF00,
      32'h80FE0001, 32'h7F0100FE, 32'hFFFF00FF,
      32'hFFFFFFFF, 32'h0000FF00, 32'h01FEFF03,
      32'h5555FF55, 32'hAAAAFFAA, 32'hFFFFFFFF,
      32'h00000000, 32'h00CC00CC, 32'hFF0000FF,
      32'h12348056, 32'hFFFFFFFF, 32'h00008000,
      32'hDEAD80EF, 32'h00000000, 32'h87658021
   };

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   madl_req_if req_bus ();
   madl_rsp_if rsp_bus ();

   motion_adaptive_line_deinterlacer_core #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // deinterlacer mirror
   logic [PIX_W-1:0] line_mem [3][MAX_W];
   logic [PIX_W-1:0] held [2];
   int unsigned      col_pos;
   int unsigned      row_pos;
   logic [CSR_W-1:0] width_reg;
   logic [CSR_W-1:0] height_reg;
   out_word_type     lineouts_due [$];

   logic [PIX_W-1:0] pixel_feed [$];
   int               pixels_queued;
   int               pixels_taken;
   int               words_checked;
   int               interp_words;
   int               csr_writes;
   int               mismatches;
   int               quiet_cycles;
   logic             pixel_taken;
   int               feed_gap;
   int               stall_left;
   bit               feed_calm;
   bit               drain_calm;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned clamp_span(input logic [CSR_W-1:0] v, input int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function automatic int green_mean(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
      return (int'(a[15:8]) + int'(b[15:8])) / 2;
   endfunction

   function automatic int abs_diff(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // per-channel floor mean, top byte left at zero
   function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] res;
      res = '0;
      for (int ch = 0; ch < 3; ch++)
         res[ch*8 +: 8] = 8'((int'(a[ch*8 +: 8]) + int'(b[ch*8 +: 8])) / 2);
      return res;
   endfunction

   task automatic take_pixel(input logic [PIX_W-1:0] pix);
      int unsigned      w, h, c, r, x;
      int               m1, m2, m3, m4, d1, d2;
      logic [PIX_W-1:0] prior;
      logic [PIX_W-1:0] ln_a [3];
      logic [PIX_W-1:0] ln_b [3];
      logic [PIX_W-1:0] ln_c [3];
      logic [PIX_W-1:0] ln_d [3];
      logic             interp;
      out_word_type     word;
      w = clamp_span(width_reg, MAX_W);
      h = clamp_span(height_reg, MAX_H);
      c = col_pos;
      r = row_pos;
      prior = line_mem[r % 3][c];
      if (c % 3 == 0) held[0] = prior;
      else if (c % 3 == 1) held[1] = prior;
      line_mem[r % 3][c] = pix;
      if (c % 3 == 2 && c < w && r % 2 == 1 && r >= 3 && r < h) begin
         x = c - 2;
         // ln_a..ln_d are rows y-1, y, y+1, y+2 at columns x..x+2
         ln_a = '{held[0], held[1], prior};
         for (int k = 0; k < 3; k++) begin
            ln_b[k] = line_mem[(r + 1) % 3][x + k];
            ln_c[k] = line_mem[(r + 2) % 3][x + k];
         end
         ln_d = '{line_mem[r % 3][x], line_mem[r % 3][x + 1], pix};
         m1 = green_mean(ln_a[0], ln_a[2]);
         m2 = green_mean(ln_b[0], ln_b[2]);
         m3 = green_mean(ln_c[0], ln_c[2]);
         m4 = green_mean(ln_d[0], ln_d[2]);
         d1 = abs_diff(m1, m3) + abs_diff(m2, m4);
         d2 = abs_diff(m1, m4) + abs_diff(m2, m3);
         interp = (d1 < d2);
         for (int k = 0; k < 3; k++) begin
            word.row    = POS_W'(r - 3);
            word.col    = POS_W'(x + k);
            word.upper  = ln_b[k];
            word.lower  = interp ? blend(ln_b[k], ln_d[k]) : ln_c[k];
            word.interp = interp;
            word.last   = (k == 2);
            lineouts_due.push_back(word);
         end
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   task automatic check_field(input string tag, input logic [PIX_W-1:0] want,
                              input logic [PIX_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %h, got %h", $time, tag, want, got);
      end
   endtask

   function automatic int gap_len(input bit calm);
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // pixel source: one word held until taken, then a random gap
   always @(negedge clock) begin : feeder
      logic             next_valid;
      logic [PIX_W-1:0] next_pixel;
      next_valid = req_bus.valid;
      next_pixel = req_bus.pixel;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_bus.valid && pixel_taken) next_valid = 1'b0;
         if (!next_valid) begin
            if (feed_gap > 0) begin
               feed_gap--;
            end else if (pixel_feed.size() > 0) begin
               next_pixel = pixel_feed.pop_front();
               next_valid = 1'b1;
               if ($urandom_range(0, 49) == 0) feed_calm = !feed_calm;
               feed_gap = gap_len(feed_calm);
            end
         end
      end
      req_bus.valid <= next_valid;
      req_bus.pixel <= next_pixel;
   end

   // result sink with random backpressure
   always @(negedge clock) begin : drainer
      logic next_ready;
      if (stall_left > 0) begin
         stall_left--;
         next_ready = 1'b0;
      end else begin
         next_ready = 1'b1;
         if ($urandom_range(0, 49) == 0) drain_calm = !drain_calm;
         if ($urandom_range(0, 3) == 0) stall_left = gap_len(drain_calm);
      end
      rsp_bus.ready <= next_ready;
   end

   always @(posedge clock) begin : observer
      out_word_type want;
      if (reset) begin
         pixel_taken <= 1'b0;
         col_pos      = 0;
         row_pos      = 0;
         held[0]      = '0;
         held[1]      = '0;
         width_reg    = LINE_WIDTH_RESET;
         height_reg   = FRAME_HEIGHT_RESET;
         quiet_cycles = 0;
      end else begin
         pixel_taken <= req_bus.valid && req_bus.ready;
         if (csr_we) begin
            csr_writes++;
            case (csr_index)
               CSR_LINE_WIDTH:   width_reg = csr_wdata;
               CSR_FRAME_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (lineouts_due.size() == 0) begin
               mismatches++;
               $display("%0t: word with nothing expected, expected none, got row %0d col %0d",
                        $time, rsp_bus.out_row, rsp_bus.out_col);
            end else begin
               want = lineouts_due.pop_front();
               words_checked++;
               if (want.interp) interp_words++;
               check_field("out_row", want.row, rsp_bus.out_row);
               check_field("out_col", want.col, rsp_bus.out_col);
               check_field("upper_pixel", want.upper, rsp_bus.upper_pixel);
               check_field("lower_pixel", want.lower, rsp_bus.lower_pixel);
               check_field("interpolated", want.interp, rsp_bus.interpolated);
               check_field("last_of_run", want.last, rsp_bus.last_of_run);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            take_pixel(req_bus.pixel);
            pixels_taken++;
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_we) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("%0t: no handshake for %0d cycles, %0d words outstanding",
                        $time, quiet_cycles, lineouts_due.size());
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   task automatic feed(input logic [PIX_W-1:0] pix);
      pixel_feed.push_back(pix);
      pixels_queued++;
   endtask

   task automatic push_pixels(input int n, input pixel_mode_type mode);
      logic [PIX_W-1:0] pix;
      for (int i = 0; i < n; i++) begin
         pix = $urandom();
         case (mode)
            PIX_PALETTE: begin
               case ($urandom_range(0, 2))
                  0: pix[15:8] = 8'h00;
                  1: pix[15:8] = 8'h80;
                  default: pix[15:8] = 8'hFF;
               endcase
            end
            PIX_FLAT_GREEN: pix[15:8] = 8'h7F + 8'($urandom_range(0, 2));
            default: ;
         endcase
         feed(pix);
      end
   endtask

   // everything taken and answered, then let the back end go quiet
   task automatic settle();
      do @(negedge clock);
      while (pixels_taken != pixels_queued || lineouts_due.size() != 0);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_frame(input logic [CSR_W-1:0] w, input logic [CSR_W-1:0] h);
      settle();
      write_reg(CSR_LINE_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
   endtask

   // run the counters back to the top of a frame
   task automatic realign(input pixel_mode_type mode);
      int unsigned w, h;
      settle();
      w = clamp_span(width_reg, MAX_W);
      h = clamp_span(height_reg, MAX_H);
      if (col_pos >= w) begin
         push_pixels(1, mode);
         settle();
      end
      if (row_pos >= h) begin
         push_pixels(w - col_pos, mode);
         settle();
      end
      if (col_pos != 0 || row_pos != 0) begin
         push_pixels((h - row_pos) * w - col_pos, mode);
         settle();
      end
   endtask

   initial begin : stimulus
      int             random_px;
      int unsigned    w, h, frames;
      pixel_mode_type mode;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_LINE_WIDTH;
      csr_wdata     = '0;
      req_bus.valid = 1'b0;
      req_bus.pixel = '0;
      rsp_bus.ready = 1'b0;
      feed_gap      = 0;
      stall_left    = 0;
      feed_calm     = 1'b0;
      drain_calm    = 1'b0;
      pixels_queued = 0;
      pixels_taken  = 0;
      words_checked = 0;
      interp_words  = 0;
      csr_writes    = 0;
      mismatches    = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_frame(12'd3, 12'd8);
      foreach (PROBE_FRAME[i]) feed(PROBE_FRAME[i]);

      // sizes too small for any triple: no words, counters still wrap
      set_frame(12'd0, 12'd4);
      push_pixels(8, PIX_NOISE);
      set_frame(12'd1, 12'd0);
      push_pixels(5, PIX_NOISE);
      set_frame(12'd2, 12'd3);
      push_pixels(6, PIX_NOISE);
      set_frame(12'd3, 12'd3);
      push_pixels(9, PIX_NOISE);

      // clamped maximum, then shrink the width in the middle of row 0
      set_frame(12'd4095, 12'd4095);
      push_pixels(50, PIX_NOISE);
      set_frame(12'd3, 12'd4);
      realign(PIX_PALETTE);

      set_frame(12'd2048, 12'd2048);
      push_pixels(40, PIX_NOISE);
      set_frame(12'd5, 12'd4);
      realign(PIX_NOISE);

      // tall frame, then cut the height below the current row
      set_frame(12'd3, 12'd2048);
      push_pixels(24, PIX_NOISE);
      settle();
      write_reg(CSR_FRAME_HEIGHT, 12'd4);
      realign(PIX_NOISE);

      // widen while still on row 0
      set_frame(12'd3, 12'd5);
      push_pixels(2, PIX_NOISE);
      settle();
      write_reg(CSR_LINE_WIDTH, 12'd9);
      realign(PIX_PALETTE);

      // grow the height partway down a frame
      set_frame(12'd5, 12'd4);
      push_pixels(10, PIX_NOISE);
      settle();
      write_reg(CSR_FRAME_HEIGHT, 12'd7);
      realign(PIX_FLAT_GREEN);

      random_px = 0;
      while (random_px < 150) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(3, 9);
         h = $urandom_range(4, 9);
         frames = (w > 12) ? 1 : $urandom_range(1, 2);
         set_frame(CSR_W'(w), CSR_W'(h));
         for (int f = 0; f < frames; f++) begin
            case ($urandom_range(0, 3))
               0: mode = PIX_PALETTE;
               1: mode = PIX_FLAT_GREEN;
               default: mode = PIX_NOISE;
            endcase
            push_pixels(w * h, mode);
            random_px += w * h;
         end
      end

      settle();
      $display("run covered %0d pixels and %0d register writes, %0d words checked",
               pixels_taken, csr_writes, words_checked);
      $display("%0d of those words were vertical averages; sizes ran from 1x1 to 2048x2048",
               interp_words);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/madl_pkg.sv
sv/madl_req_if.sv
sv/madl_rsp_if.sv
sv/madl_front.sv
sv/madl_queue.sv
sv/madl_back.sv
sv/motion_adaptive_line_deinterlacer_core.sv
tb/tb.sv
